/* sv/chm_pkg.sv */
// Shared constants, codes and types of the chained hash map core.
// No dependencies; every other file but chm_ram imports this package.
`default_nettype none
package chm_pkg;
	localparam int POOL_ENTRIES = 4096;
	localparam int BUCKET_SLOTS = 1024;
	localparam int SLOT_W = $clog2(POOL_ENTRIES + 1);
	localparam int BKT_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int CNT_W = 11;
	localparam int KEY_W = 32;
	localparam int KIND_W = 3;
	localparam int USED_W = 13;
	localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(5);

	localparam logic [KIND_W-1:0] KIND_GET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FIND = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERASE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0] lookup_key;
		logic [KEY_W-1:0] value_in;
		logic [BKT_W-1:0] bucket;
	} chm_job_t;

	typedef struct packed {
		logic init_busy;
	} chm_back_stat_t;

	// Clamp a pool link to a valid slot, zero otherwise
	function automatic logic [SLOT_W-1:0] slot_ok(input logic [SLOT_W-1:0] s);
		return (s <= SLOT_W'(POOL_ENTRIES)) ? s : '0;
	endfunction
endpackage
`default_nettype wire

/* sv/chm_req_if.sv */
// Request channel of the chained hash map core.
// Depends on chm_pkg for field widths.
`default_nettype none
interface chm_req_if import chm_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [KEY_W-1:0] value_in;
	modport source(output valid, kind, lookup_key, value_in, input ready);
	modport sink(input valid, kind, lookup_key, value_in, output ready);
endinterface
`default_nettype wire

/* sv/chm_rsp_if.sv */
// Response channel of the chained hash map core.
// Depends on chm_pkg for field widths.
`default_nettype none
interface chm_rsp_if import chm_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [KEY_W-1:0] value_out;
	logic found;
	logic status;
	logic [USED_W-1:0] entry_count;
	modport source(output valid, value_out, found, status, entry_count, input ready);
	modport sink(input valid, value_out, found, status, entry_count, output ready);
endinterface
`default_nettype wire

/* sv/chm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module chm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/chm_front.sv */
// Front end: accepts requests and computes the bucket index (iterative modulo).
// Depends on chm_pkg and chm_req_if.
`default_nettype none
module chm_front import chm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [CNT_W-1:0] bucket_count,
	input wire chm_back_stat_t stat,
	chm_req_if.sink req,
	output logic job_valid,
	input wire logic job_ready,
	output chm_job_t job
);
	localparam int DIG = 4;
	localparam int DIV_STEPS = 64 / DIG;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0] st_q;
	chm_job_t job_q;
	logic [63:0] div_q;
	logic [CNT_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] rem_nx;
	logic [63:0] div_nx;

	// Clamp the modulus to 1..BUCKET_SLOTS
	always_comb begin
		if (bucket_count == '0) begin
			n = CNT_W'(1);
		end else if (bucket_count > CNT_W'(BUCKET_SLOTS)) begin
			n = CNT_W'(BUCKET_SLOTS);
		end else begin
			n = bucket_count;
		end
	end

	// Four restoring remainder steps per cycle
	always_comb begin
		rem_nx = rem_q;
		div_nx = div_q;
		for (int i = 0; i < DIG; i++) begin
			rem_nx = {rem_nx[CNT_W-2:0], div_nx[63]};
			div_nx = {div_nx[62:0], 1'b0};
			if (rem_nx >= n) begin
				rem_nx = rem_nx - n;
			end
		end
	end

	assign req.ready = (st_q == F_IDLE) && !stat.init_busy;
	assign job_valid = (st_q == F_PUSH);
	assign job = job_q;

	// Sequence accept, divide and hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (req.valid && req.ready) begin
						st_q <= (req.kind >= KIND_CLEAR) ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						st_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// Hold the request and the remainder datapath
	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && req.valid && req.ready) begin
			job_q.kind <= req.kind;
			job_q.lookup_key <= req.lookup_key;
			job_q.value_in <= req.value_in;
			job_q.bucket <= '0;
			div_q <= {{32{req.lookup_key[KEY_W-1]}}, req.lookup_key};
			rem_q <= '0;
			step_q <= '0;
		end else if (st_q == F_DIV) begin
			div_q <= div_nx;
			rem_q <= rem_nx;
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				job_q.bucket <= rem_nx[BKT_W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

/* sv/chm_queue.sv */
// Two-entry job queue between the front and back ends.
// Depends on chm_pkg for the job type.
`default_nettype none
module chm_queue import chm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire chm_job_t push_data,
	output logic pop_valid,
	input wire logic pop,
	output chm_job_t pop_data
);
	chm_job_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = slot_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

/* sv/chm_back.sv */
// Back end: walks bucket chains in pool memory and applies each operation.
// Depends on chm_pkg, chm_ram and chm_rsp_if.
`default_nettype none
module chm_back import chm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_pop,
	input wire chm_job_t job,
	output chm_back_stat_t stat,
	chm_rsp_if.source rsp
);
	localparam logic [2:0] B_INIT = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_HEAD = 3'd2;
	localparam logic [2:0] B_LINK = 3'd3;
	localparam logic [2:0] B_RD = 3'd4;
	localparam logic [2:0] B_CMP = 3'd5;
	localparam logic [2:0] B_ACT = 3'd6;
	localparam logic [2:0] B_DONE = 3'd7;

	logic [2:0] st_q;
	logic clr_q;
	chm_job_t job_q;
	logic [BKT_W-1:0] sweep_q;
	logic [SLOT_W-1:0] cur_q, prev_q, head_q, hit_q, steps_q;
	logic [USED_W-1:0] used_q;
	logic found_q, status_q;
	logic [KEY_W-1:0] hitval_q, vout_q;
	logic rsp_valid_q;
	logic signed [KEY_W-1:0] rsp_value_q;
	logic rsp_found_q, rsp_status_q;
	logic [USED_W-1:0] rsp_count_q;

	logic head_we, link_we, key_we, val_we;
	logic [BKT_W-1:0] head_waddr;
	logic [SLOT_W-1:0] head_wdata, head_rdata;
	logic [SLOT_W-1:0] link_waddr, link_wdata, link_rdata, pool_waddr, val_waddr;
	logic [KEY_W-1:0] key_rdata, val_rdata, val_wdata;
	logic [SLOT_W-1:0] nxt, new_slot;
	logic match, full, walk_end, pushes, do_push;

	assign nxt = slot_ok(link_rdata);
	assign match = (key_rdata == job_q.lookup_key);
	assign full = (used_q >= USED_W'(POOL_ENTRIES));
	assign new_slot = SLOT_W'(used_q) + SLOT_W'(1);
	assign walk_end = (nxt == '0) || (steps_q == SLOT_W'(POOL_ENTRIES - 1));
	assign pushes = (job_q.kind == KIND_INSERT) ||
		((job_q.kind == KIND_GET || job_q.kind == KIND_PUT) && !found_q);
	assign do_push = (st_q == B_ACT) && pushes && !full;
	assign job_pop = (st_q == B_IDLE) && job_valid;
	assign stat.init_busy = (st_q == B_INIT);

	// Select write ports of the head and pool memories
	always_comb begin
		head_we = 1'b0;
		head_waddr = job_q.bucket;
		head_wdata = new_slot;
		link_we = 1'b0;
		link_waddr = new_slot;
		link_wdata = head_q;
		key_we = do_push;
		pool_waddr = new_slot;
		val_we = do_push;
		val_waddr = new_slot;
		val_wdata = (job_q.kind == KIND_GET) ? '0 : job_q.value_in;
		if (st_q == B_INIT) begin
			head_we = 1'b1;
			head_waddr = sweep_q;
			head_wdata = '0;
		end else if (st_q == B_CMP && job_q.kind == KIND_ERASE && match) begin
			if (prev_q == '0) begin
				head_we = 1'b1;
				head_wdata = nxt;
			end else begin
				link_we = 1'b1;
				link_waddr = prev_q;
				link_wdata = nxt;
			end
		end else if (do_push) begin
			head_we = 1'b1;
			link_we = 1'b1;
		end else if (st_q == B_ACT && job_q.kind == KIND_PUT && found_q) begin
			val_we = 1'b1;
			val_waddr = hit_q;
		end
	end

	chm_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKET_SLOTS)) u_heads (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(job_q.bucket), .rdata(head_rdata)
	);
	chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES + 1)) u_keys (
		.clk(clk), .we(key_we), .waddr(pool_waddr), .wdata(job_q.lookup_key),
		.raddr(cur_q), .rdata(key_rdata)
	);
	chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES + 1)) u_values (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(cur_q), .rdata(val_rdata)
	);
	chm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_ENTRIES + 1)) u_links (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(cur_q), .rdata(link_rdata)
	);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_INIT;
			clr_q <= 1'b0;
			sweep_q <= '0;
			used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise the result on hand-off, drop it once taken
			if (st_q == B_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				B_INIT: begin
					sweep_q <= sweep_q + BKT_W'(1);
					if (sweep_q == BKT_W'(BUCKET_SLOTS - 1)) begin
						st_q <= clr_q ? B_DONE : B_IDLE;
					end
				end
				B_IDLE: begin
					if (job_valid) begin
						if (job.kind == KIND_CLEAR) begin
							used_q <= '0;
							clr_q <= 1'b1;
							sweep_q <= '0;
							st_q <= B_INIT;
						end else if (job.kind > KIND_CLEAR) begin
							st_q <= B_DONE;
						end else begin
							st_q <= B_HEAD;
						end
					end
				end
				B_HEAD: st_q <= B_LINK;
				B_LINK: st_q <= (slot_ok(head_rdata) == '0) ? B_ACT : B_RD;
				B_RD: st_q <= B_CMP;
				B_CMP: begin
					if (walk_end || (match && job_q.kind != KIND_ERASE)) begin
						st_q <= B_ACT;
					end else begin
						st_q <= B_RD;
					end
				end
				B_ACT: begin
					if (do_push) begin
						used_q <= USED_W'(new_slot);
					end
					st_q <= B_DONE;
				end
				B_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						clr_q <= 1'b0;
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// Walk and result datapath
	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				job_q <= job;
				found_q <= 1'b0;
				status_q <= 1'b0;
				hitval_q <= '0;
				vout_q <= '0;
				prev_q <= '0;
				steps_q <= '0;
				hit_q <= '0;
			end
			B_LINK: begin
				head_q <= head_rdata;
				cur_q <= slot_ok(head_rdata);
			end
			B_CMP: begin
				if (match) begin
					if (!found_q) begin
						found_q <= 1'b1;
						hit_q <= cur_q;
						hitval_q <= val_rdata;
					end
				end else begin
					prev_q <= cur_q;
				end
				cur_q <= nxt;
				steps_q <= steps_q + SLOT_W'(1);
			end
			B_ACT: begin
				if (job_q.kind == KIND_FIND || job_q.kind == KIND_ERASE ||
						(job_q.kind == KIND_GET && found_q)) begin
					vout_q <= hitval_q;
				end else if (pushes && full) begin
					status_q <= 1'b1;
				end else if (job_q.kind != KIND_GET) begin
					vout_q <= job_q.value_in;
				end
			end
			B_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_value_q <= vout_q;
					rsp_found_q <= found_q;
					rsp_status_q <= status_q;
					rsp_count_q <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.found = rsp_found_q;
	assign rsp.status = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	ap_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(POOL_ENTRIES)) else $error("pool count overflow");
	ap_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> !full) else $error("push into full pool");
	ap_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_INIT) |-> !job_pop) else $error("job popped during sweep");
	ap_walk_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_RD) |-> (cur_q != '0 && cur_q <= SLOT_W'(POOL_ENTRIES)))
		else $error("walk on empty slot");
endmodule
`default_nettype wire

/* sv/chained_hash_map_core.sv */
// Top level of the chained hash map core: front end, job queue, back end.
// Depends on chm_pkg, chm_req_if, chm_rsp_if, chm_front, chm_queue, chm_back.
//
// Usage: send get/put/insert/find/erase/clear transactions on req; every one
// returns exactly one transaction on rsp, in order. The user must write
// bucket_count through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce this. bucket_count is clamped to 1..1024. The front end
// iterates the bucket modulo (four remainder bits per cycle), except for clear
// and unused kinds. The back end then reads the bucket head and walks the chain
// in pool memory (one registered read per entry); clear sweeps the bucket heads.
// Front and back overlap through a two-entry queue, so sustained throughput is
// set by the slower of the front modulo and the chain walk.
// After reset the back end sweeps all 1024 bucket heads to zero; req.ready
// stays low meanwhile, configuration writes are taken as ever.
// When rsp stalls, one result waits in the output register while the queue
// and front end keep accepting until they fill.
`default_nettype none
module chained_hash_map_core import chm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata,
	chm_req_if.sink req,
	chm_rsp_if.source rsp
);
	logic [CNT_W-1:0] bucket_count_q;
	chm_back_stat_t stat;
	chm_job_t fq_data, qb_data;
	logic fq_valid, fq_ready, qb_valid, qb_pop;

	// Hold the bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	chm_front u_front (
		.clk(clk), .arst_n(arst_n), .bucket_count(bucket_count_q), .stat(stat),
		.req(req), .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_data)
	);

	chm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(fq_valid), .push_ready(fq_ready),
		.push_data(fq_data), .pop_valid(qb_valid), .pop(qb_pop), .pop_data(qb_data)
	);

	chm_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qb_valid), .job_pop(qb_pop),
		.job(qb_data), .stat(stat), .rsp(rsp)
	);
endmodule
`default_nettype wire
